### design/five_char_timer_display_top_assert.svh
// ----------------------------------------------------------------------------
// five_char_timer_display_top_assert: assertion macros
// Implication checks on the rising clock edge, off while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIVE_CHAR_TIMER_DISPLAY_TOP_ASSERT_SVH
`define FIVE_CHAR_TIMER_DISPLAY_TOP_ASSERT_SVH

// same-cycle implication
`define TCD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants of the timer display
// Mode codes, special counter words, divide constants, ASCII codes, stage types.
// ----------------------------------------------------------------------------
package tcd_pkg;

   localparam logic [2:0] MODE_RENDER       = 3'd0;
   localparam logic [2:0] MODE_COUNT_UP_SEC = 3'd1;
   localparam logic [2:0] MODE_COUNT_UP_MIN = 3'd2;
   localparam logic [2:0] MODE_COUNTDOWN    = 3'd3;
   localparam logic [2:0] MODE_LONG_DOWN    = 3'd4;
   localparam logic [2:0] MODE_SET_VALUE    = 3'd5;
   localparam logic [2:0] MODE_SET_RAW      = 3'd6;

   localparam logic [15:0] WORD_SIX_H     = 16'h1fff;
   localparam logic [15:0] WORD_HUNDRED_M = 16'h1ffe;
   localparam logic [15:0] WORD_FIN       = 16'h1ffd;
   localparam logic [15:0] WORD_HUNDRED_H = 16'h1ffc;

   localparam logic [15:0] STATIC_LIMIT = 16'd6000;
   localparam logic [14:0] SIX_HOURS    = 15'd21600;

   // reciprocal multipliers, exact over the value ranges used here
   localparam logic [31:0] DIV1000_MAGIC = 32'h10624dd3;  // >> 38, 32-bit input
   localparam logic [22:0] DIV60W_MAGIC  = 23'd4473925;   // >> 28, 23-bit input
   localparam logic [15:0] DIV60_MAGIC   = 16'd34953;     // >> 21, 15-bit input
   localparam logic [7:0]  DIV10_MAGIC   = 8'd205;        // >> 11, input < 1029

   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_COLON  = 8'h3a;
   localparam logic [7:0] ASCII_SPACE  = 8'h20;
   localparam logic [7:0] ASCII_DASH   = 8'h2d;
   localparam logic [7:0] ASCII_PLUS   = 8'h2b;
   localparam logic [7:0] ASCII_LPAREN = 8'h28;
   localparam logic [7:0] ASCII_RPAREN = 8'h29;
   localparam logic [7:0] ASCII_ONE    = 8'h31;
   localparam logic [7:0] ASCII_SIX    = 8'h36;
   localparam logic [7:0] ASCII_LOW_H  = 8'h68;
   localparam logic [7:0] ASCII_UP_H   = 8'h48;
   localparam logic [7:0] ASCII_LOW_M  = 8'h6d;
   localparam logic [7:0] ASCII_UP_M   = 8'h4d;
   localparam logic [7:0] ASCII_UP_A   = 8'h41;

   typedef enum logic [2:0] {
      DK_ZERO,
      DK_TIME,
      DK_SIX_H,
      DK_HUNDRED_M,
      DK_HUNDRED_H,
      DK_DASH
   } disp_kind_type;

   // command beat with the time base already divided down
   typedef struct packed {
      logic [2:0]  mode;
      logic [16:0] arg_sum;
      logic [15:0] raw;
      logic [15:0] sec;
      logic [12:0] min13;
   } cmd_type;

   // what to show; alt is the colon for time and dashes, upper case for 100m/100h
   typedef struct packed {
      disp_kind_type kind;
      logic          alt;
      logic          keep;
      logic [14:0]   elapsed;
      logic [15:0]   word;
   } sel_type;

endpackage

### design/tcd_timebase.sv
// ----------------------------------------------------------------------------
// tcd_timebase: input register and millisecond clock division
// Registers the request, then derives seconds and minutes by reciprocal multiplies.
// ----------------------------------------------------------------------------
module tcd_timebase (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [2:0]       mode,
   input  logic [31:0]      time_ms,
   input  logic [9:0]       arg_major,
   input  logic [12:0]      arg_minor,
   input  logic [15:0]      raw_value,
   output logic             out_valid,
   input  logic             out_ready,
   output tcd_pkg::cmd_type out_cmd
);
   import tcd_pkg::*;

   logic        v1_ff, v2_ff, v3_ff;
   logic        rdy1, rdy2, rdy3;
   logic [2:0]  mode1_ff, mode2_ff;
   logic [31:0] time1_ff;
   logic [9:0]  major1_ff;
   logic [12:0] minor1_ff;
   logic [15:0] raw1_ff, raw2_ff;
   logic [16:0] sum2_ff;
   logic [22:0] sfull2_ff;
   cmd_type     cmd3_ff;

   logic [63:0] sec_prod;
   logic [44:0] min_prod;
   logic [22:0] sfull_in;
   logic [16:0] sum_in;
   cmd_type     cmd_in;

   function automatic logic [16:0] arg_major_mul(input logic [9:0] val);
      // times 60 as (times 64) minus (times 4)
      arg_major_mul = {1'b0, val, 6'd0} - {5'd0, val, 2'd0};
   endfunction

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      sec_prod = {32'd0, time1_ff} * {32'd0, DIV1000_MAGIC};
      sfull_in = sec_prod[60:38];
      sum_in   = 17'(arg_major_mul(major1_ff)) + {4'd0, minor1_ff};
   end

   always_comb begin
      min_prod      = {22'd0, sfull2_ff} * {22'd0, DIV60W_MAGIC};
      cmd_in.mode    = mode2_ff;
      cmd_in.arg_sum = sum2_ff;
      cmd_in.raw     = raw2_ff;
      cmd_in.sec     = sfull2_ff[15:0];
      cmd_in.min13   = min_prod[40:28];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mode1_ff  <= mode;
         time1_ff  <= time_ms;
         major1_ff <= arg_major;
         minor1_ff <= arg_minor;
         raw1_ff   <= raw_value;
      end
      if (rdy2) begin
         mode2_ff  <= mode1_ff;
         raw2_ff   <= raw1_ff;
         sum2_ff   <= sum_in;
         sfull2_ff <= sfull_in;
      end
      if (rdy3) cmd3_ff <= cmd_in;
   end

   assign out_valid = v3_ff;
   assign out_cmd   = cmd3_ff;

endmodule

### design/tcd_ctrl.sv
// ----------------------------------------------------------------------------
// tcd_ctrl: counter word register and display selection
// Applies commands to the counter word and picks what a render beat shows.
// ----------------------------------------------------------------------------
`include "five_char_timer_display_top_assert.svh"

module tcd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tcd_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output tcd_pkg::sel_type out_sel
);
   import tcd_pkg::*;

   logic [15:0] word_ff, word_in;
   logic        v_ff;
   sel_type     sel_ff, sel_in;
   logic        take;

   logic        even;
   logic [12:0] now13, end13;
   logic [14:0] now15, diff15;
   logic [12:0] sdown13, mup13, mdown13;

   assign in_ready = !v_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      even    = !in_cmd.sec[0];
      now13   = in_cmd.sec[12:0];
      now15   = in_cmd.sec[14:0];
      end13   = word_ff[12:0];
      // 13-bit wrap covers both the positive and the wrapped-negative cases
      sdown13 = end13 - now13;
      mup13   = in_cmd.min13 - end13;
      mdown13 = end13 - in_cmd.min13;
      diff15  = now15 - word_ff[14:0];
   end

   always_comb begin
      word_in        = word_ff;
      sel_in.kind    = DK_ZERO;
      sel_in.alt     = 1'b0;
      sel_in.keep    = 1'b0;
      sel_in.elapsed = 15'd0;
      case (in_cmd.mode)
         MODE_RENDER: begin
            sel_in.keep = 1'b1;
            if (word_ff == WORD_SIX_H) begin
               sel_in.kind = DK_SIX_H;
               sel_in.keep = 1'b0;
            end else if (word_ff == WORD_HUNDRED_M) begin
               sel_in.kind = DK_HUNDRED_M;
               sel_in.alt  = !even;
               sel_in.keep = 1'b0;
            end else if (word_ff == WORD_FIN) begin
               sel_in.kind = DK_DASH;
               sel_in.alt  = !even;
            end else if (word_ff == WORD_HUNDRED_H) begin
               sel_in.kind = DK_HUNDRED_H;
               sel_in.alt  = !even;
            end else if (word_ff[15:13] == 3'b000) begin
               if (word_ff >= STATIC_LIMIT) begin
                  sel_in.kind = DK_HUNDRED_M;
               end else begin
                  sel_in.kind    = DK_TIME;
                  sel_in.alt     = 1'b1;
                  sel_in.elapsed = word_ff[14:0];
               end
            end else if (word_ff[15:13] == 3'b001) begin
               if (end13 == now13) begin
                  word_in     = WORD_FIN;
                  sel_in.kind = DK_DASH;
                  sel_in.alt  = 1'b1;
               end else begin
                  sel_in.kind    = DK_TIME;
                  sel_in.alt     = end13 > now13;
                  sel_in.elapsed = {2'd0, sdown13};
               end
            end else if (word_ff[15:13] == 3'b010) begin
               sel_in.kind    = DK_TIME;
               sel_in.alt     = even;
               sel_in.elapsed = {2'd0, mup13};
            end else if (word_ff[15:13] == 3'b011) begin
               if (end13 == in_cmd.min13) begin
                  word_in     = WORD_FIN;
                  sel_in.kind = DK_DASH;
                  sel_in.alt  = 1'b1;
               end else begin
                  sel_in.kind    = DK_TIME;
                  sel_in.alt     = even;
                  sel_in.elapsed = {2'd0, mdown13};
               end
            end else begin
               sel_in.alt = 1'b1;
               if (now15 >= word_ff[14:0]) begin
                  if (diff15 > SIX_HOURS) begin
                     sel_in.kind = DK_SIX_H;
                  end else begin
                     sel_in.kind    = DK_TIME;
                     sel_in.elapsed = diff15;
                  end
               end else begin
                  // start ahead of now: one second short of the 15-bit wrap
                  sel_in.kind    = DK_TIME;
                  sel_in.elapsed = diff15 - 15'd1;
               end
            end
         end
         MODE_COUNT_UP_SEC: word_in = {1'b1, now15};
         MODE_COUNT_UP_MIN: word_in = {3'b010, in_cmd.min13};
         MODE_COUNTDOWN:    word_in = {3'b001, now13 + in_cmd.arg_sum[12:0]};
         MODE_LONG_DOWN:    word_in = {3'b011, in_cmd.min13 + in_cmd.arg_sum[12:0]};
         MODE_SET_VALUE:    word_in = {2'b00, in_cmd.arg_sum[13:0]};
         MODE_SET_RAW:      word_in = in_cmd.raw;
         default:           word_in = word_ff;
      endcase
      sel_in.word = word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= 1'b0;
         word_ff <= 16'd0;
      end else begin
         if (in_ready) v_ff <= in_valid;
         if (take) word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) sel_ff <= sel_in;
   end

   assign out_valid = v_ff;
   assign out_sel   = sel_ff;

   `TCD_ASSERT_NEXT(a_hold_word, !take, $stable(word_ff), "word moved without a beat")
   `TCD_ASSERT_NEXT(a_render_word, take && (in_cmd.mode == MODE_RENDER), (word_ff == $past(word_ff)) || (word_ff == WORD_FIN), "render changed word to other than finished")
   `TCD_ASSERT_NEXT(a_cmd_blank, take && (in_cmd.mode != MODE_RENDER), (sel_ff.kind == DK_ZERO) && !sel_ff.keep, "command beat not blank")
   `TCD_ASSERT_NOW(a_sel_word, v_ff, sel_ff.word == word_ff, "result word differs from register")

endmodule

### design/tcd_format.sv
// ----------------------------------------------------------------------------
// tcd_format: digit split and character generation
// Splits a count into minutes and seconds, then into digits or fixed strings, into the result register.
// ----------------------------------------------------------------------------
module tcd_format (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tcd_pkg::sel_type in_sel,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       char_0,
   output logic [7:0]       char_1,
   output logic [7:0]       char_2,
   output logic [7:0]       char_3,
   output logic [7:0]       char_4,
   output logic             keep_refreshing,
   output logic [15:0]      counter_word
);
   import tcd_pkg::*;

   logic          va_ff, vb_ff, rdya, rdyb;
   disp_kind_type kind_ff;
   logic          alt_ff, keep_ff;
   logic [15:0]   word_ff;
   logic [9:0]    mins_ff, mins_in;
   logic [5:0]    secs_ff, secs_in;
   logic [30:0]   prod60;
   logic [14:0]   back60;

   logic [17:0]   prod_mt;
   logic [13:0]   prod_st;
   logic [5:0]    mt;
   logic [2:0]    st;
   logic [9:0]    mo_full;
   logic [5:0]    so_full;
   logic [7:0]    c0_in, c1_in, c2_in, c3_in, c4_in;
   logic [7:0]    c0_ff, c1_ff, c2_ff, c3_ff, c4_ff;
   logic          keep_out_ff;
   logic [15:0]   word_out_ff;

   assign rdyb     = !vb_ff || out_ready;
   assign rdya     = !va_ff || rdyb;
   assign in_ready = rdya;

   always_comb begin
      prod60  = {16'd0, in_sel.elapsed} * {15'd0, DIV60_MAGIC};
      mins_in = prod60[30:21];
      back60  = 15'(mins_in) * 15'd60;
      secs_in = 6'(in_sel.elapsed - back60);
   end

   always_comb begin
      prod_mt = {8'd0, mins_ff} * {10'd0, DIV10_MAGIC};
      mt      = prod_mt[16:11];
      prod_st = {8'd0, secs_ff} * {6'd0, DIV10_MAGIC};
      st      = prod_st[13:11];
      mo_full = mins_ff - 10'(mt) * 10'd10;
      so_full = secs_ff - 6'(st) * 6'd10;

      c0_in = 8'd0;
      c1_in = 8'd0;
      c2_in = 8'd0;
      c3_in = 8'd0;
      c4_in = 8'd0;
      case (kind_ff)
         DK_TIME: begin
            if (mins_ff < 10'd10) c0_in = ASCII_ZERO;
            else if (mins_ff < 10'd100) c0_in = ASCII_ZERO + {2'd0, mt};
            else c0_in = {2'd0, mt} + (ASCII_UP_A - 8'd10);
            c1_in = ASCII_ZERO + {4'd0, mo_full[3:0]};
            c2_in = alt_ff ? ASCII_COLON : ASCII_SPACE;
            c3_in = ASCII_ZERO + {5'd0, st};
            c4_in = ASCII_ZERO + {4'd0, so_full[3:0]};
         end
         DK_SIX_H: begin
            c0_in = ASCII_LPAREN;
            c1_in = ASCII_SIX;
            c2_in = ASCII_LOW_H;
            c3_in = ASCII_PLUS;
            c4_in = ASCII_RPAREN;
         end
         DK_HUNDRED_M: begin
            c0_in = ASCII_ONE;
            c1_in = ASCII_ZERO;
            c2_in = ASCII_ZERO;
            c3_in = alt_ff ? ASCII_UP_M : ASCII_LOW_M;
            c4_in = ASCII_PLUS;
         end
         DK_HUNDRED_H: begin
            c0_in = ASCII_ONE;
            c1_in = ASCII_ZERO;
            c2_in = ASCII_ZERO;
            c3_in = alt_ff ? ASCII_UP_H : ASCII_LOW_H;
            c4_in = ASCII_PLUS;
         end
         DK_DASH: begin
            c0_in = ASCII_DASH;
            c1_in = ASCII_DASH;
            c2_in = alt_ff ? ASCII_COLON : ASCII_SPACE;
            c3_in = ASCII_DASH;
            c4_in = ASCII_DASH;
         end
         default: begin
            c0_in = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdya) va_ff <= in_valid;
         if (rdyb) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdya) begin
         kind_ff <= in_sel.kind;
         alt_ff  <= in_sel.alt;
         keep_ff <= in_sel.keep;
         word_ff <= in_sel.word;
         mins_ff <= mins_in;
         secs_ff <= secs_in;
      end
      if (rdyb) begin
         c0_ff       <= c0_in;
         c1_ff       <= c1_in;
         c2_ff       <= c2_in;
         c3_ff       <= c3_in;
         c4_ff       <= c4_in;
         keep_out_ff <= keep_ff;
         word_out_ff <= word_ff;
      end
   end

   assign out_valid       = vb_ff;
   assign char_0          = c0_ff;
   assign char_1          = c1_ff;
   assign char_2          = c2_ff;
   assign char_3          = c3_ff;
   assign char_4          = c4_ff;
   assign keep_refreshing = keep_out_ff;
   assign counter_word    = word_out_ff;

endmodule

### design/five_char_timer_display_top.sv
// ----------------------------------------------------------------------------
// five_char_timer_display_top: five-character mm:ss timer display
// Pipeline: six register stages between the request beat and the result.
// Throughput: one beat per cycle while rsp_stall is low; a full stage holds while the one after it holds.
// Reset: synchronous; empties the pipeline and clears the counter word to 00:00.
// ----------------------------------------------------------------------------
module five_char_timer_display_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_time_ms,
   input  logic [9:0]  req_arg_major,
   input  logic [12:0] req_arg_minor,
   input  logic [15:0] req_raw_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_0,
   output logic [7:0]  rsp_char_1,
   output logic [7:0]  rsp_char_2,
   output logic [7:0]  rsp_char_3,
   output logic [7:0]  rsp_char_4,
   output logic        rsp_keep_refreshing,
   output logic [15:0] rsp_counter_word
);
   import tcd_pkg::*;

   logic    in_ready;
   logic    tb_valid, tb_ready;
   cmd_type tb_cmd;
   logic    ctl_valid, ctl_ready;
   sel_type ctl_sel;

   assign req_stall = !in_ready;

   tcd_timebase u_timebase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .mode      (req_mode),
      .time_ms   (req_time_ms),
      .arg_major (req_arg_major),
      .arg_minor (req_arg_minor),
      .raw_value (req_raw_value),
      .out_valid (tb_valid),
      .out_ready (tb_ready),
      .out_cmd   (tb_cmd)
   );

   tcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tb_valid),
      .in_ready  (tb_ready),
      .in_cmd    (tb_cmd),
      .out_valid (ctl_valid),
      .out_ready (ctl_ready),
      .out_sel   (ctl_sel)
   );

   tcd_format u_format (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (ctl_valid),
      .in_ready        (ctl_ready),
      .in_sel          (ctl_sel),
      .out_valid       (rsp_valid),
      .out_ready       (!rsp_stall),
      .char_0          (rsp_char_0),
      .char_1          (rsp_char_1),
      .char_2          (rsp_char_2),
      .char_3          (rsp_char_3),
      .char_4          (rsp_char_4),
      .keep_refreshing (rsp_keep_refreshing),
      .counter_word    (rsp_counter_word)
   );

endmodule
